// ----- rtl/ttb_pkg.sv -----
package ttb_pkg;

  // Field widths
  localparam int POS_W   = 24;          // signed position, Q7.16
  localparam int UV_W    = 16;          // unsigned texcoord, Q1.15
  localparam int UV_FRAC = UV_W - 1;

  // Datapath widths
  localparam int DP_W   = POS_W + 1;     // position delta
  localparam int DUV_W  = UV_W + 1;      // texcoord delta
  localparam int PROD_W = DP_W + DUV_W;  // one cross term
  localparam int NUM_W  = PROD_W + 1;    // difference of two cross terms
  localparam int DET_W  = 2 * DUV_W + 1; // UV determinant
  localparam int Q_W    = POS_W + 1;     // quotient bits kept by the divider
  localparam int DIV_SH = UV_FRAC + 1;   // numerator pre-shift, one extra bit for rounding

  localparam int N_COMP = 6;

  // Stream widths
  localparam int S_TDATA_W = ((3 * POS_W + 2 * UV_W + 7) / 8) * 8;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = ((N_COMP * POS_W + 7) / 8) * 8;
  localparam int M_TUSER_W = 1;

  // Corner codes
  localparam logic [S_TUSER_W-1:0] CORNER_0 = 2'd0;
  localparam logic [S_TUSER_W-1:0] CORNER_1 = 2'd1;
  localparam logic [S_TUSER_W-1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DET_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- rtl/ttb_mul.sv -----
// Shared signed multiplier, product registered.
module ttb_mul (
  input  logic                              clk_i,
  input  logic signed [ttb_pkg::DP_W-1:0]   a_i,
  input  logic signed [ttb_pkg::DUV_W-1:0]  b_i,
  output logic signed [ttb_pkg::PROD_W-1:0] p_o
);

  logic signed [ttb_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/ttb_div.sv -----
// Restoring divider: round(num * 2^DIV_SH / den / 2), ties away from zero,
// clamped to POS_W signed. One quotient bit per cycle. den must be nonzero.
module ttb_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttb_pkg::div_req_t req_i,
  output ttb_pkg::div_rsp_t rsp_o
);

  localparam int AN_W  = ttb_pkg::NUM_W;
  localparam int ADW   = ttb_pkg::DET_W;
  localparam int QW    = ttb_pkg::Q_W;
  localparam int SH    = ttb_pkg::DIV_SH;
  localparam int PW    = ttb_pkg::POS_W;
  localparam int D_W   = AN_W + SH;
  localparam int CMP_W = (D_W > ADW + QW) ? D_W : ADW + QW;
  localparam int CW    = $clog2(QW + 1);

  localparam logic [QW-1:0] MAXV   = {{(QW - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
  localparam logic [QW-1:0] MINMAG = MAXV + 1'b1;
  localparam logic [PW-1:0] SAT_POS = {1'b0, {(PW - 1){1'b1}}};
  localparam logic [PW-1:0] SAT_NEG = {1'b1, {(PW - 1){1'b0}}};

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_FIN  = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic            neg_q, ovf_q;
  logic [AN_W-1:0] an_q;
  logic [ADW-1:0]  ad_q;
  logic [ADW-1:0]  r_q;
  logic [QW-1:0]   sh_q, q_q;
  logic [PW-1:0]   quo_q;

  logic [AN_W-1:0]  num_u, an_abs;
  logic [ADW-1:0]   den_u, ad_abs;
  logic [CMP_W-1:0] dext, dcmp;
  logic             ovf;
  logic [ADW:0]     r2, diff;
  logic             ge;
  logic [QW:0]      rnd;
  logic [QW-1:0]    mag;
  logic [PW-1:0]    quo_d;

  always_comb begin
    num_u  = req_i.num;
    den_u  = req_i.den;
    an_abs = num_u[AN_W-1] ? (~num_u + 1'b1) : num_u;
    ad_abs = den_u[ADW-1] ? (~den_u + 1'b1) : den_u;
    dext   = CMP_W'({an_q, {SH{1'b0}}});
    dcmp   = CMP_W'({ad_q, {QW{1'b0}}});
    ovf    = dext >= dcmp;
    r2     = {r_q, sh_q[QW-1]};
    diff   = r2 - {1'b0, ad_q};
    ge     = r2 >= {1'b0, ad_q};
    rnd    = {1'b0, q_q} + 1'b1;
    mag    = rnd[QW:1];
    if (neg_q) begin
      quo_d = (ovf_q || (mag > MINMAG)) ? SAT_NEG : (~mag[PW-1:0] + 1'b1);
    end else begin
      quo_d = (ovf_q || (mag > MAXV)) ? SAT_POS : mag[PW-1:0];
    end
    st_d = st_q;
    case (st_q)
      D_IDLE:  if (req_i.start) st_d = D_CHK;
      D_CHK:   st_d = ovf ? D_FIN : D_RUN;
      D_RUN:   if (cnt_q == CW'(1)) st_d = D_FIN;
      D_FIN:   st_d = D_IDLE;
      default: st_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == D_FIN);
      if (st_q == D_CHK) begin
        cnt_q <= CW'(QW);
      end else if (st_q == D_RUN) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      D_IDLE: begin
        if (req_i.start) begin
          an_q  <= an_abs;
          ad_q  <= ad_abs;
          neg_q <= num_u[AN_W-1] ^ den_u[ADW-1];
        end
      end
      D_CHK: begin
        ovf_q <= ovf;
        r_q   <= dext[QW +: ADW];
        sh_q  <= dext[QW-1:0];
        q_q   <= '0;
      end
      D_RUN: begin
        r_q  <= ge ? diff[ADW-1:0] : r2[ADW-1:0];
        q_q  <= {q_q[QW-2:0], ge};
        sh_q <= {sh_q[QW-2:0], 1'b0};
      end
      D_FIN: begin
        quo_q <= quo_d;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- rtl/triangle_tangent_bitangent.sv -----
// Channel  Dir  Handshake               tdata (low bit up)                 tuser
// s_axis   in   tvalid/tready           pos_x, pos_y, pos_z, tex_u, tex_v  corner
// m_axis   out  tvalid/tready           tangent_x/y/z, bitangent_x/y/z     degenerate
//
// Corners 0 and 1 are stored, the unused code 3 is ignored; neither drops tready.
// Corner 2 holds tready low until its result enters the output register, also through
// any output stall: the determinant, then per component states S_MUL0 to S_MUL2 and
// a divide (check, 25 quotient bits, round, done; bits skipped if the check saturates).
// A zero determinant skips the divides. Reset zeroes corners 0 and 1, empties the output
// register. A stalled result waits there; the next triangle is still taken.
module triangle_tangent_bitangent (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic [ttb_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  // corner
  input  logic [ttb_pkg::S_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [ttb_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  // degenerate
  output logic [ttb_pkg::M_TUSER_W-1:0]      m_axis_tuser_o
);

  localparam int PW   = ttb_pkg::POS_W;
  localparam int UW   = ttb_pkg::UV_W;
  localparam int DPW  = ttb_pkg::DP_W;
  localparam int DUW  = ttb_pkg::DUV_W;
  localparam int PRW  = ttb_pkg::PROD_W;
  localparam int NW   = ttb_pkg::NUM_W;
  localparam int DTW  = ttb_pkg::DET_W;
  localparam int NC   = ttb_pkg::N_COMP;

  // sequencer
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL0 = 3'd1;  // issue first cross term
  localparam logic [2:0] S_MUL1 = 3'd2;  // issue second, latch first
  localparam logic [2:0] S_MUL2 = 3'd3;  // difference ready
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       det_stage_q;
  logic [2:0] comp_q;
  logic       deg_q;

  // stored corners; corner 2 is held only for the computation
  logic [PW-1:0] p0_q [3];
  logic [PW-1:0] p1_q [3];
  logic [PW-1:0] p2_q [3];
  logic [UW-1:0] t0_q [2];
  logic [UW-1:0] t1_q [2];
  logic [UW-1:0] t2_q [2];

  logic signed [PRW-1:0] acc_q;
  logic signed [DTW-1:0] det_q;
  logic [PW-1:0]         res_q [NC];

  logic                            m_valid_q;
  logic [ttb_pkg::M_TDATA_W-1:0]   m_data_q;
  logic                            m_deg_q;

  logic s_acc;
  logic out_free;

  logic [PW-1:0] in_pos [3];
  logic [UW-1:0] in_tex [2];

  logic [1:0]            axis;
  logic                  bitan;
  logic [PW-1:0]         p0_s, p1_s, p2_s;
  logic signed [DPW-1:0] dp1, dp2;
  logic signed [DUW-1:0] du1, dv1, du2, dv2;
  logic signed [DPW-1:0] mul_a;
  logic signed [DUW-1:0] mul_b;
  logic signed [PRW-1:0] mul_p;
  logic signed [NW-1:0]  num;
  logic                  ph1;

  ttb_pkg::div_req_t div_req;
  ttb_pkg::div_rsp_t div_rsp;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign in_pos[0] = s_axis_tdata_i[0 +: PW];
  assign in_pos[1] = s_axis_tdata_i[PW +: PW];
  assign in_pos[2] = s_axis_tdata_i[2*PW +: PW];
  assign in_tex[0] = s_axis_tdata_i[3*PW +: UW];
  assign in_tex[1] = s_axis_tdata_i[3*PW+UW +: UW];

  // component order: tangent x/y/z, then bitangent x/y/z
  always_comb begin
    case (comp_q)
      3'd0:    begin axis = 2'd0; bitan = 1'b0; end
      3'd1:    begin axis = 2'd1; bitan = 1'b0; end
      3'd2:    begin axis = 2'd2; bitan = 1'b0; end
      3'd3:    begin axis = 2'd0; bitan = 1'b1; end
      3'd4:    begin axis = 2'd1; bitan = 1'b1; end
      3'd5:    begin axis = 2'd2; bitan = 1'b1; end
      default: begin axis = 2'd0; bitan = 1'b0; end
    endcase
    case (axis)
      2'd0:    begin p0_s = p0_q[0]; p1_s = p1_q[0]; p2_s = p2_q[0]; end
      2'd1:    begin p0_s = p0_q[1]; p1_s = p1_q[1]; p2_s = p2_q[1]; end
      default: begin p0_s = p0_q[2]; p1_s = p1_q[2]; p2_s = p2_q[2]; end
    endcase
  end

  // edge deltas
  assign dp1 = {p1_s[PW-1], p1_s} - {p0_s[PW-1], p0_s};
  assign dp2 = {p2_s[PW-1], p2_s} - {p0_s[PW-1], p0_s};
  assign du1 = {1'b0, t1_q[0]} - {1'b0, t0_q[0]};
  assign dv1 = {1'b0, t1_q[1]} - {1'b0, t0_q[1]};
  assign du2 = {1'b0, t2_q[0]} - {1'b0, t0_q[0]};
  assign dv2 = {1'b0, t2_q[1]} - {1'b0, t0_q[1]};

  // operand select: term A in S_MUL0, term B in S_MUL1, result = A - B
  //   det:       du1*dv2 - dv1*du2
  //   tangent:   dp1*dv2 - dp2*dv1
  //   bitangent: dp2*du1 - dp1*du2
  assign ph1 = (state_q == S_MUL1);

  always_comb begin
    if (det_stage_q) begin
      mul_a = ph1 ? {{(DPW - DUW){dv1[DUW-1]}}, dv1} : {{(DPW - DUW){du1[DUW-1]}}, du1};
      mul_b = ph1 ? du2 : dv2;
    end else if (!bitan) begin
      mul_a = ph1 ? dp2 : dp1;
      mul_b = ph1 ? dv1 : dv2;
    end else begin
      mul_a = ph1 ? dp1 : dp2;
      mul_b = ph1 ? du2 : du1;
    end
  end

  ttb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign num = {acc_q[PRW-1], acc_q} - {mul_p[PRW-1], mul_p};

  assign div_req.start = (state_q == S_MUL2) && !det_stage_q;
  assign div_req.num   = num;
  assign div_req.den   = det_q;

  ttb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_2)) state_d = S_MUL0;
      end
      S_MUL0: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        if (!det_stage_q) begin
          state_d = S_DIV;
        end else if (num[DTW-1:0] == '0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MUL0;
        end
      end
      S_DIV: begin
        if (div_rsp.done) state_d = (comp_q == 3'(NC - 1)) ? S_OUT : S_MUL0;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and corner store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      det_stage_q <= 1'b0;
      comp_q      <= '0;
      deg_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p0_q[i] <= '0;
        p1_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        t0_q[i] <= '0;
        t1_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_0)) begin
        p0_q <= in_pos;
        t0_q <= in_tex;
      end
      if (s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_1)) begin
        p1_q <= in_pos;
        t1_q <= in_tex;
      end
      if (s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_2)) begin
        det_stage_q <= 1'b1;
        comp_q      <= '0;
      end
      if ((state_q == S_MUL2) && det_stage_q) begin
        det_stage_q <= 1'b0;
        deg_q       <= (num[DTW-1:0] == '0);
      end
      if ((state_q == S_DIV) && div_rsp.done) begin
        comp_q <= comp_q + 1'b1;
      end
      if ((state_q == S_OUT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_2)) begin
      p2_q <= in_pos;
      t2_q <= in_tex;
    end
    if (state_q == S_MUL1) begin
      acc_q <= mul_p;
    end
    if ((state_q == S_MUL2) && det_stage_q) begin
      det_q <= num[DTW-1:0];
    end
    if ((state_q == S_DIV) && div_rsp.done) begin
      res_q[comp_q] <= div_rsp.quo;
    end
    if ((state_q == S_OUT) && out_free) begin
      m_deg_q  <= deg_q;
      m_data_q <= deg_q ? '0 :
                  ttb_pkg::M_TDATA_W'({res_q[5], res_q[4], res_q[3],
                                       res_q[2], res_q[1], res_q[0]});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_deg_q;

endmodule

// ----- rtl/ttb_checker.sv -----
module ttb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_i,
  input logic [ttb_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [ttb_pkg::M_TDATA_W-1:0] m_axis_tdata_i,
  input logic [ttb_pkg::M_TUSER_W-1:0] m_axis_tuser_i
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_i;

  // corner 2 starts the computation and blocks the input
  a_busy_after_c2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i == ttb_pkg::CORNER_2) |=> !s_axis_tready_i)
    else $error("input ready right after a corner 2 transaction");

  // a stored corner never stalls the input
  a_ready_after_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i != ttb_pkg::CORNER_2) |=> s_axis_tready_i)
    else $error("input stalled after a store-only transaction");

  // degenerate triangles return zero vectors
  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i[0] |-> (m_axis_tdata_i == '0))
    else $error("degenerate result with nonzero vectors");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("output changed while stalled");

endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
